// File: hw/rtl/lz4_block_decompressor_top_defines.svh
// Assertion macros shared by the LZ4 block decompressor RTL.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef LZ4_BLOCK_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZ4_BLOCK_DECOMPRESSOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LZ4BD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZ4BD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lz4bd_pkg.sv
// Package for the LZ4 block decompressor: item types, codes and constants.
// No dependencies.
package lz4bd_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int WINDOW_BYTES   = 65536;
  localparam int WIN_AW         = $clog2(WINDOW_BYTES);
  localparam int CAP_W          = 24;
  localparam int WCOUNT_W       = 24;
  localparam int CFG_AW         = 2;
  localparam int CFG_DW         = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET         = '1;
  localparam logic [CFG_AW-1:0] REG_CAPACITY_ADDR = 2'd0;

  localparam logic [3:0] NIBBLE_FULL = 4'd15;
  localparam logic [7:0] EXT_MORE    = 8'd255;
  localparam logic [3:0] MATCH_BASE  = 4'd4;

  // input opcodes
  localparam logic [1:0] OP_BYTE       = 2'd0;
  localparam logic [1:0] OP_COPY       = 2'd1;
  localparam logic [1:0] OP_START_IND  = 2'd2;
  localparam logic [1:0] OP_START_LINK = 2'd3;

  typedef enum logic [2:0] {
    PH_TOKEN  = 3'd0,
    PH_LITEXT = 3'd1,
    PH_LIT    = 3'd2,
    PH_OFFLO  = 3'd3,
    PH_OFFHI  = 3'd4,
    PH_MATEXT = 3'd5,
    PH_COPY   = 3'd6,
    PH_ENDED  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_NOSPACE   = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic                out_valid;
    logic [7:0]          out_byte;
    logic                busy_res;
    logic                block_done;
    logic [1:0]          status;
    logic [WCOUNT_W-1:0] written_count;
  } out_item_t;

endpackage

// File: hw/rtl/lz4_block_decompressor_top.sv
// LZ4 block decompressor top level: parser, counters and 64 KiB history memory.
// Depends on lz4bd_pkg and lz4_block_decompressor_top_defines.svh.
//
// One item per clock: each transfer on the input is a compressed byte, a copy
// step or a block start, and yields exactly one result transfer. The parser
// state lives in registers updated at the input transfer; the history is a
// single-port-write, synchronous-read 64 KiB memory. A copy step issues its
// history read at the input transfer and the byte appears in the next cycle in
// the output register, where it is also written back into history when the
// result transfers out. A copy whose source is the byte still in the output
// register (offset one, back to back) takes it through a forwarding path, so
// overlapping matches repeat correctly at full rate. Each result is registered;
// throughput is one item per cycle, and the input stalls only while the output
// register is full and the output is stalled.
// No clearing pass: history entries are only read after they were written.
`include "lz4_block_decompressor_top_defines.svh"

module lz4_block_decompressor_top #(
  parameter int COUNT_BITS = lz4bd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lz4bd_pkg::in_item_t           in_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output lz4bd_pkg::out_item_t          out_data,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lz4bd_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [lz4bd_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [lz4bd_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CB  = COUNT_BITS;
  localparam int LW  = (CB > lz4bd_pkg::CAP_W) ? CB : lz4bd_pkg::CAP_W;
  localparam int WLW = (CB > lz4bd_pkg::WCOUNT_W) ? CB : lz4bd_pkg::WCOUNT_W;
  localparam int AW  = lz4bd_pkg::WIN_AW;
  localparam logic [CB-1:0] CountMax = '1;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  logic [lz4bd_pkg::CAP_W-1:0] cap_r;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr == lz4bd_pkg::REG_CAPACITY_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lz4bd_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[lz4bd_pkg::CAP_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == lz4bd_pkg::REG_CAPACITY_ADDR) ?
                      lz4bd_pkg::CFG_DW'(cap_r) : '0;

  // ---------------------------------------------------------------------
  // parser state
  // ---------------------------------------------------------------------
  lz4bd_pkg::phase_t  phase_r, phase_nxt;
  lz4bd_pkg::status_t err_r, err_nxt;
  logic [CB-1:0]      lit_rem_r, lit_rem_nxt;
  logic [CB-1:0]      mat_rem_r, mat_rem_nxt;
  logic [15:0]        off_r, off_nxt;
  logic [3:0]         nib_r, nib_nxt;
  logic [CB-1:0]      bw_r, bw_nxt;

  // output register (stage 2)
  logic               s2_v_r;
  logic               s2_have_r;
  logic               s2_copy_r;
  logic               s2_fwd_r;
  logic [7:0]         s2_byte_r;
  logic [AW-1:0]      s2_waddr_r;
  logic               s2_busy_r;
  logic               s2_done_r;
  logic [1:0]         s2_status_r;
  logic [lz4bd_pkg::WCOUNT_W-1:0] s2_count_r;
  logic [7:0]         s2_data;

  logic               in_acc, out_xfer;
  logic               have_byte, is_copy, ended_ok;
  logic [AW-1:0]      rd_addr;
  logic               fwd_hit;

  // history memory
  logic [7:0]         hist_mem [lz4bd_pkg::WINDOW_BYTES];
  logic [7:0]         mem_rdata_r;

  assign in_stall  = s2_v_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_xfer  = s2_v_r && !out_stall;

  // ---------------------------------------------------------------------
  // space and length arithmetic
  // ---------------------------------------------------------------------
  logic [LW-1:0] cap_ext, max_ext, lim_ext;
  logic [CB-1:0] lim, room;
  logic [CB:0]   lit_sum_w, mat_sum_w, mat_sum4_w;
  logic [CB-1:0] lit_sum, mat_sum, mat_sum4;
  logic [CB-1:0] lit_n, mat_len;
  logic          lit_long, mat_long;
  logic [15:0]   off_new;
  logic [CB-1:0] lit_dec, mat_dec;
  logic          start_lit, start_mat;

  assign cap_ext = LW'(cap_r);
  assign max_ext = LW'(CountMax);
  assign lim_ext = (cap_ext < max_ext) ? cap_ext : max_ext;
  assign lim     = lim_ext[CB-1:0];
  assign room    = (lim > bw_r) ? (lim - bw_r) : '0;

  // saturating extension sums
  assign lit_sum_w  = {1'b0, lit_rem_r} + (CB+1)'(in_data.in_byte);
  assign mat_sum_w  = {1'b0, mat_rem_r} + (CB+1)'(in_data.in_byte);
  assign mat_sum4_w = mat_sum_w + (CB+1)'(lz4bd_pkg::MATCH_BASE);
  assign lit_sum    = lit_sum_w[CB]  ? CountMax : lit_sum_w[CB-1:0];
  assign mat_sum    = mat_sum_w[CB]  ? CountMax : mat_sum_w[CB-1:0];
  assign mat_sum4   = mat_sum4_w[CB] ? CountMax : mat_sum4_w[CB-1:0];

  assign lit_n    = (phase_r == lz4bd_pkg::PH_TOKEN) ? CB'(in_data.in_byte[7:4]) : lit_sum;
  assign mat_len  = (phase_r == lz4bd_pkg::PH_OFFHI) ?
                    (CB'(nib_r) + CB'(lz4bd_pkg::MATCH_BASE)) : mat_sum4;
  assign lit_long = (lit_n == CountMax) || (lit_n > room);
  assign mat_long = (mat_len == CountMax) || (mat_len > room);

  assign off_new  = {in_data.in_byte, off_r[7:0]};
  assign lit_dec  = lit_rem_r - 1'b1;
  assign mat_dec  = mat_rem_r - 1'b1;
  assign rd_addr  = bw_r[AW-1:0] - off_r[AW-1:0];

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    phase_nxt   = phase_r;
    err_nxt     = err_r;
    lit_rem_nxt = lit_rem_r;
    mat_rem_nxt = mat_rem_r;
    off_nxt     = off_r;
    nib_nxt     = nib_r;
    bw_nxt      = bw_r;
    have_byte   = 1'b0;
    is_copy     = 1'b0;
    ended_ok    = 1'b0;
    start_lit   = 1'b0;
    start_mat   = 1'b0;

    if ((in_data.opcode == lz4bd_pkg::OP_START_IND) ||
        (in_data.opcode == lz4bd_pkg::OP_START_LINK)) begin
      // block start drops any parse or match; independent start resets count
      if (in_data.opcode == lz4bd_pkg::OP_START_IND) begin
        bw_nxt = '0;
      end
      phase_nxt   = lz4bd_pkg::PH_TOKEN;
      lit_rem_nxt = '0;
      mat_rem_nxt = '0;
      off_nxt     = '0;
      nib_nxt     = '0;
      err_nxt     = lz4bd_pkg::ST_OK;
    end else if (err_r == lz4bd_pkg::ST_OK) begin
      if (in_data.opcode == lz4bd_pkg::OP_BYTE) begin
        unique case (phase_r)
          lz4bd_pkg::PH_TOKEN: begin
            nib_nxt = in_data.in_byte[3:0];
            if (in_data.in_byte[7:4] == lz4bd_pkg::NIBBLE_FULL) begin
              lit_rem_nxt = CB'(lz4bd_pkg::NIBBLE_FULL);
              phase_nxt   = lz4bd_pkg::PH_LITEXT;
              if (in_data.in_last) begin
                err_nxt     = lz4bd_pkg::ST_MALFORMED;
                mat_rem_nxt = '0;
              end
            end else begin
              start_lit = 1'b1;
            end
          end
          lz4bd_pkg::PH_LITEXT: begin
            lit_rem_nxt = lit_sum;
            if (in_data.in_byte == lz4bd_pkg::EXT_MORE) begin
              if (in_data.in_last) begin
                err_nxt     = lz4bd_pkg::ST_MALFORMED;
                mat_rem_nxt = '0;
              end
            end else begin
              start_lit = 1'b1;
            end
          end
          lz4bd_pkg::PH_LIT: begin
            if (room == '0) begin
              err_nxt     = lz4bd_pkg::ST_NOSPACE;
              mat_rem_nxt = '0;
            end else begin
              have_byte   = 1'b1;
              bw_nxt      = bw_r + 1'b1;
              lit_rem_nxt = lit_dec;
              if (lit_dec == '0) begin
                if (in_data.in_last) begin
                  phase_nxt = lz4bd_pkg::PH_ENDED;
                  ended_ok  = 1'b1;
                end else begin
                  phase_nxt = lz4bd_pkg::PH_OFFLO;
                end
              end else if (in_data.in_last) begin
                err_nxt     = lz4bd_pkg::ST_MALFORMED;
                mat_rem_nxt = '0;
              end
            end
          end
          lz4bd_pkg::PH_OFFLO: begin
            off_nxt   = {8'd0, in_data.in_byte};
            phase_nxt = lz4bd_pkg::PH_OFFHI;
            if (in_data.in_last) begin
              err_nxt     = lz4bd_pkg::ST_MALFORMED;
              mat_rem_nxt = '0;
            end
          end
          lz4bd_pkg::PH_OFFHI: begin
            off_nxt = off_new;
            if ((off_new == '0) || (CB'(off_new) > bw_r)) begin
              err_nxt     = lz4bd_pkg::ST_MALFORMED;
              mat_rem_nxt = '0;
            end else if (nib_r == lz4bd_pkg::NIBBLE_FULL) begin
              mat_rem_nxt = CB'(lz4bd_pkg::NIBBLE_FULL);
              phase_nxt   = lz4bd_pkg::PH_MATEXT;
              if (in_data.in_last) begin
                err_nxt     = lz4bd_pkg::ST_MALFORMED;
                mat_rem_nxt = '0;
              end
            end else begin
              start_mat = 1'b1;
            end
          end
          lz4bd_pkg::PH_MATEXT: begin
            mat_rem_nxt = mat_sum;
            if (in_data.in_byte == lz4bd_pkg::EXT_MORE) begin
              if (in_data.in_last) begin
                err_nxt     = lz4bd_pkg::ST_MALFORMED;
                mat_rem_nxt = '0;
              end
            end else begin
              start_mat = 1'b1;
            end
          end
          lz4bd_pkg::PH_COPY: begin
            err_nxt     = lz4bd_pkg::ST_BUSY;
            mat_rem_nxt = '0;
          end
          lz4bd_pkg::PH_ENDED: begin
            err_nxt     = lz4bd_pkg::ST_MALFORMED;
            mat_rem_nxt = '0;
          end
          default: begin
            err_nxt     = lz4bd_pkg::ST_MALFORMED;
            mat_rem_nxt = '0;
          end
        endcase

        // literal run length known: early-end and space checks, then end, offset or literal phase
        if (start_lit) begin
          if (in_data.in_last && (lit_n != '0)) begin
            err_nxt     = lz4bd_pkg::ST_MALFORMED;
            mat_rem_nxt = '0;
          end else if (lit_long) begin
            err_nxt     = lz4bd_pkg::ST_NOSPACE;
            mat_rem_nxt = '0;
          end else if (lit_n == '0) begin
            if (in_data.in_last) begin
              phase_nxt = lz4bd_pkg::PH_ENDED;
              ended_ok  = 1'b1;
            end else begin
              phase_nxt = lz4bd_pkg::PH_OFFLO;
            end
          end else begin
            lit_rem_nxt = lit_n;
            phase_nxt   = lz4bd_pkg::PH_LIT;
          end
        end

        // match length known: space check first, then early end
        if (start_mat) begin
          if (mat_long) begin
            err_nxt     = lz4bd_pkg::ST_NOSPACE;
            mat_rem_nxt = '0;
          end else if (in_data.in_last) begin
            err_nxt     = lz4bd_pkg::ST_MALFORMED;
            mat_rem_nxt = '0;
          end else begin
            mat_rem_nxt = mat_len;
            phase_nxt   = lz4bd_pkg::PH_COPY;
          end
        end
      end else if ((phase_r == lz4bd_pkg::PH_COPY) && (mat_rem_r != '0)) begin
        // copy step; the byte itself arrives from history next cycle
        if (room == '0) begin
          err_nxt     = lz4bd_pkg::ST_NOSPACE;
          mat_rem_nxt = '0;
        end else begin
          have_byte   = 1'b1;
          is_copy     = 1'b1;
          bw_nxt      = bw_r + 1'b1;
          mat_rem_nxt = mat_dec;
          if (mat_dec == '0) begin
            phase_nxt = lz4bd_pkg::PH_TOKEN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lz4bd_pkg::PH_TOKEN;
      err_r     <= lz4bd_pkg::ST_OK;
      lit_rem_r <= '0;
      mat_rem_r <= '0;
      off_r     <= '0;
      nib_r     <= '0;
      bw_r      <= '0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      err_r     <= err_nxt;
      lit_rem_r <= lit_rem_nxt;
      mat_rem_r <= mat_rem_nxt;
      off_r     <= off_nxt;
      nib_r     <= nib_nxt;
      bw_r      <= bw_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // output register and history write-back
  // ---------------------------------------------------------------------
  // the byte held in stage 2 is written back at its output transfer, the
  // same edge a following copy may read it: forward in that case
  assign fwd_hit = s2_v_r && s2_have_r && (s2_waddr_r == rd_addr);
  assign s2_data = s2_fwd_r ? s2_byte_r : mem_rdata_r;

  logic [WLW-1:0] wcount_ext;
  assign wcount_ext = WLW'(bw_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (in_acc) begin
      s2_v_r <= 1'b1;
    end else if (out_xfer) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s2_have_r   <= have_byte;
      s2_copy_r   <= is_copy;
      s2_waddr_r  <= bw_r[AW-1:0];
      s2_busy_r   <= (err_nxt == lz4bd_pkg::ST_OK) &&
                     (phase_nxt == lz4bd_pkg::PH_COPY) && (mat_rem_nxt != '0);
      s2_done_r   <= ended_ok && (err_nxt == lz4bd_pkg::ST_OK);
      s2_status_r <= err_nxt;
      s2_count_r  <= wcount_ext[lz4bd_pkg::WCOUNT_W-1:0];
      if (!is_copy) begin
        s2_fwd_r  <= 1'b1;
        s2_byte_r <= in_data.in_byte;
      end else begin
        s2_fwd_r  <= fwd_hit;
        s2_byte_r <= s2_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer && s2_have_r) begin
      hist_mem[s2_waddr_r] <= s2_data;
    end
    if (in_acc) begin
      mem_rdata_r <= hist_mem[rd_addr];
    end
  end

  assign out_valid              = s2_v_r;
  assign out_data.out_valid     = s2_have_r;
  assign out_data.out_byte      = s2_have_r ? s2_data : 8'd0;
  assign out_data.busy_res      = s2_busy_r;
  assign out_data.block_done    = s2_done_r;
  assign out_data.status        = s2_status_r;
  assign out_data.written_count = s2_count_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `LZ4BD_ASSERT_NOW(a_copy_offset_in_range,
    (phase_r == lz4bd_pkg::PH_COPY) && (err_r == lz4bd_pkg::ST_OK),
    (off_r != '0) && (CB'(off_r) <= bw_r),
    "pending match offset outside written bytes")
  `LZ4BD_ASSERT_NEXT(a_count_steps_by_one,
    in_acc && have_byte,
    bw_r == CB'($past(bw_r) + 1'b1),
    "byte count did not advance by one on an output byte")
  `LZ4BD_ASSERT_NOW(a_error_quiets_result,
    s2_v_r && (s2_status_r != lz4bd_pkg::ST_OK),
    !s2_busy_r && !s2_done_r,
    "busy or done reported with an error")
  `LZ4BD_ASSERT_NOW(a_copy_has_byte,
    s2_v_r && s2_copy_r,
    s2_have_r,
    "history read without an output byte")

endmodule

// File: tb/lz4_block_decompressor_top_tb.sv
// Self-checking testbench for lz4_block_decompressor_top: LZ4 block streams in, bytes checked out.
// Depends on lz4bd_pkg and the lz4_block_decompressor_top RTL; needs nothing else.
`timescale 1ns / 1ps

module lz4_block_decompressor_top_tb;
  import lz4bd_pkg::*;

  localparam int unsigned CNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
  localparam int unsigned LONG_HOLD = 300;
  localparam int          N_PHASES  = 6;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT pins. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  in_item_t          in_data     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  lz4_block_decompressor_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  in_item_t    compressed_q[$];   // items waiting for the driver
  in_item_t    blk_q[$];          // scratch: one block under construction
  out_item_t   decoded_q[$];      // expected results, oldest first
  int unsigned err_cnt     = 0;
  int unsigned result_cnt  = 0;
  int unsigned tx_idle_pct = 15;
  int unsigned rx_idle_pct = 88;
  int unsigned rx_hold     = 0;   // long receiver hold-off, cycles left
  logic        hold_arm    = 1'b0;

  // ---------------------------------------------------------------------------
  // Decoder model state: parser, counters, sticky error and history window.
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0] cap_reg    = CAP_RESET;
  phase_t           pr_phase   = PH_TOKEN;
  status_t          pr_err     = ST_OK;
  int unsigned      lit_left   = 0;
  int unsigned      run_left   = 0;   // match bytes still to copy
  int unsigned      back_dist  = 0;   // match offset
  int unsigned      low_nib    = 0;   // token match nibble
  int unsigned      produced   = 0;   // bytes out since independent start
  bit [7:0]         hist_mem [WINDOW_BYTES];
  bit               byte_out;
  bit [7:0]         byte_val;
  bit               seq_end;          // block ended cleanly on this item

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                result_cnt, name, got, want));
  endtask

  function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
    longint unsigned s;
    s = a;
    s += b;
    return (s > CNT_MAX) ? CNT_MAX : int'(s);
  endfunction

  function automatic int unsigned room_left();
    int unsigned lim;
    lim = (cap_reg < CNT_MAX) ? cap_reg : CNT_MAX;
    return (lim > produced) ? lim - produced : 0;
  endfunction

  function automatic bit too_long(int unsigned len);
    return (len >= CNT_MAX) || (len > room_left());
  endfunction

  // any error kills a pending match
  function automatic void fail_with(status_t code);
    pr_err   = code;
    run_left = 0;
  endfunction

  function automatic bit emit(bit [7:0] b);
    if (room_left() == 0) begin
      fail_with(ST_NOSPACE);
      return 1'b0;
    end
    hist_mem[produced[WIN_AW-1:0]] = b;
    produced++;
    byte_out = 1'b1;
    byte_val = b;
    return 1'b1;
  endfunction

  function automatic void start_lits(int unsigned n, bit last);
    if (last && n > 0) fail_with(ST_MALFORMED);
    else if (too_long(n)) fail_with(ST_NOSPACE);
    else if (n == 0) begin
      if (last) begin
        pr_phase = PH_ENDED;
        seq_end  = 1'b1;
      end else begin
        pr_phase = PH_OFFLO;
      end
    end else begin
      lit_left = n;
      pr_phase = PH_LIT;
    end
  endfunction

  function automatic void start_run(int unsigned len, bit last);
    if (too_long(len)) fail_with(ST_NOSPACE);
    else if (last) fail_with(ST_MALFORMED);
    else begin
      run_left = len;
      pr_phase = PH_COPY;
    end
  endfunction

  function automatic void take_byte(bit [7:0] b, bit last);
    case (pr_phase)
      PH_TOKEN: begin
        low_nib = b[3:0];
        if (b[7:4] == NIBBLE_FULL) begin
          lit_left = NIBBLE_FULL;
          pr_phase = PH_LITEXT;
          if (last) fail_with(ST_MALFORMED);
        end else begin
          start_lits(b[7:4], last);
        end
      end
      PH_LITEXT: begin
        lit_left = sat_sum(lit_left, b);
        if (b == EXT_MORE) begin
          if (last) fail_with(ST_MALFORMED);
        end else begin
          start_lits(lit_left, last);
        end
      end
      PH_LIT: begin
        if (emit(b)) begin
          lit_left--;
          if (lit_left == 0) begin
            if (last) begin
              pr_phase = PH_ENDED;
              seq_end  = 1'b1;
            end else begin
              pr_phase = PH_OFFLO;
            end
          end else if (last) begin
            fail_with(ST_MALFORMED);
          end
        end
      end
      PH_OFFLO: begin
        back_dist = b;
        pr_phase  = PH_OFFHI;
        if (last) fail_with(ST_MALFORMED);
      end
      PH_OFFHI: begin
        back_dist = {16'h0, b, back_dist[7:0]};
        // bad offset wins over the early-end check
        if (back_dist == 0 || back_dist > produced) fail_with(ST_MALFORMED);
        else if (low_nib == NIBBLE_FULL) begin
          run_left = NIBBLE_FULL;
          pr_phase = PH_MATEXT;
          if (last) fail_with(ST_MALFORMED);
        end else begin
          start_run(low_nib + MATCH_BASE, last);
        end
      end
      PH_MATEXT: begin
        run_left = sat_sum(run_left, b);
        if (b == EXT_MORE) begin
          if (last) fail_with(ST_MALFORMED);
        end else begin
          start_run(sat_sum(run_left, MATCH_BASE), last);
        end
      end
      PH_COPY: fail_with(ST_BUSY);
      default: fail_with(ST_MALFORMED);   // byte after the block ended
    endcase
  endfunction

  function automatic void copy_step();
    int unsigned src;
    if (pr_phase != PH_COPY || run_left == 0) return;
    src = produced - back_dist;
    if (!emit(hist_mem[src[WIN_AW-1:0]])) return;
    run_left--;
    if (run_left == 0) pr_phase = PH_TOKEN;
  endfunction

  function automatic out_item_t decode_item(in_item_t it);
    out_item_t r;
    byte_out = 1'b0;
    byte_val = 8'h00;
    seq_end  = 1'b0;
    if (it.opcode == OP_START_IND || it.opcode == OP_START_LINK) begin
      if (it.opcode == OP_START_IND) produced = 0;
      pr_phase  = PH_TOKEN;
      lit_left  = 0;
      run_left  = 0;
      back_dist = 0;
      low_nib   = 0;
      pr_err    = ST_OK;
    end else if (pr_err == ST_OK) begin
      if (it.opcode == OP_BYTE) take_byte(it.in_byte, it.in_last);
      else copy_step();
    end
    r.out_valid     = byte_out;
    r.out_byte      = byte_out ? byte_val : 8'h00;
    r.busy_res      = (pr_err == ST_OK) && (pr_phase == PH_COPY) && (run_left > 0);
    r.block_done    = seq_end && (pr_err == ST_OK);
    r.status        = pr_err;
    r.written_count = produced[WCOUNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers the next pending item whenever the slot is free. A stalled
  // payload holds; valid drops only when the sender idles or runs dry.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (compressed_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data  <= compressed_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, armed from the stimulus for one cycle.
  always @(posedge clk) begin
    if (hold_arm) rx_hold <= LONG_HOLD;
    else if (rx_hold != 0) rx_hold <= rx_hold - 1;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every input transfer, checks every result transfer
  // against the oldest prediction, and drives out_stall. Prediction comes
  // first so a result in the same cycle as its input would still find its expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decoded_q.push_back(decode_item(in_data));
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", result_cnt));
        end else begin
          want = decoded_q.pop_front();
          check_field("out_valid", out_data.out_valid, want.out_valid);
          check_field("out_byte", out_data.out_byte, want.out_byte);
          check_field("busy_res", out_data.busy_res, want.busy_res);
          check_field("block_done", out_data.block_done, want.block_done);
          check_field("status", out_data.status, want.status);
          check_field("written_count", out_data.written_count, want.written_count);
        end
        result_cnt++;
      end
      out_stall <= (rx_hold != 0) || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  int unsigned gen_count = 0;   // generator's idea of bytes written
  bit          gen_dirty = 1'b0;  // stream was corrupted: next start independent

  function automatic in_item_t mk(logic [1:0] op, logic [7:0] b, logic last);
    in_item_t it;
    it.opcode  = op;
    it.in_byte = b;
    it.in_last = last;
    return it;
  endfunction

  // mostly short lengths, now and then long enough for a 255 extension byte
  function automatic int unsigned pick_len(int unsigned big_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < big_pct) return $urandom_range(256, 290);
    if (r < 75) return $urandom_range(0, 6);
    return $urandom_range(7, 30);
  endfunction

  function automatic void push_ext(int unsigned rem);
    while (rem >= EXT_MORE) begin
      blk_q.push_back(mk(OP_BYTE, EXT_MORE, 1'b0));
      rem -= EXT_MORE;
    end
    blk_q.push_back(mk(OP_BYTE, rem[7:0], 1'b0));
  endfunction

  // Well-formed block with random content: nseq literal+match sequences and a
  // closing literals-only sequence whose last item carries in_last.
  task automatic gen_block(bit linked, int nseq);
    int unsigned lits, mcode, offs, lim;
    bit [3:0]    hi, lo;
    blk_q.delete();
    blk_q.push_back(mk(linked ? OP_START_LINK : OP_START_IND, 8'($urandom()), 1'b0));
    if (!linked) begin
      gen_count = 0;
      gen_dirty = 1'b0;
    end
    for (int s = 0; s < nseq; s++) begin
      lits  = pick_len(3);
      if (gen_count == 0 && lits == 0) lits = 1;
      mcode = pick_len(2);
      hi    = (lits >= NIBBLE_FULL) ? NIBBLE_FULL : lits[3:0];
      lo    = (mcode >= NIBBLE_FULL) ? NIBBLE_FULL : mcode[3:0];
      blk_q.push_back(mk(OP_BYTE, {hi, lo}, 1'b0));
      if (lits >= NIBBLE_FULL) push_ext(lits - NIBBLE_FULL);
      repeat (lits) blk_q.push_back(mk(OP_BYTE, 8'($urandom()), 1'b0));
      gen_count += lits;
      lim  = (gen_count > 65535) ? 65535 : gen_count;
      // short offsets give overlapping copies
      offs = ($urandom_range(99) < 75) ? $urandom_range(1, (lim < 8) ? lim : 8)
                                       : $urandom_range(1, lim);
      blk_q.push_back(mk(OP_BYTE, offs[7:0], 1'b0));
      blk_q.push_back(mk(OP_BYTE, offs[15:8], 1'b0));
      if (mcode >= NIBBLE_FULL) push_ext(mcode - NIBBLE_FULL);
      repeat (mcode + MATCH_BASE) blk_q.push_back(mk(OP_COPY, 8'($urandom()), 1'b0));
      gen_count += mcode + MATCH_BASE;
    end
    lits = pick_len(3);
    hi   = (lits >= NIBBLE_FULL) ? NIBBLE_FULL : lits[3:0];
    blk_q.push_back(mk(OP_BYTE, {hi, 4'($urandom())}, lits == 0));
    if (lits >= NIBBLE_FULL) push_ext(lits - NIBBLE_FULL);
    for (int i = 0; i < lits; i++)
      blk_q.push_back(mk(OP_BYTE, 8'($urandom()), i == lits - 1));
    gen_count += lits;
  endtask

  // Occasionally break a block: swap in junk, flip in_last, drop or add items.
  task automatic corrupt_block();
    int unsigned idx;
    idx = $urandom_range(1, blk_q.size() - 1);
    case ($urandom_range(5))
      0: blk_q[idx] = mk(2'($urandom()), 8'($urandom()), 1'($urandom()));
      1: blk_q[idx].in_last = ~blk_q[idx].in_last;
      2: blk_q.delete(idx);
      3: blk_q.insert(idx, mk(OP_BYTE, 8'($urandom()), 1'b0));
      4: blk_q.push_back(mk(OP_BYTE, 8'($urandom()), 1'($urandom())));
      default: blk_q.push_back(mk(OP_COPY, 8'($urandom()), 1'b0));
    endcase
    gen_dirty = 1'b1;
  endtask

  // Wait until every item went in and every expected result came out.
  task automatic wait_drained();
    do @(negedge clk);
    while (compressed_q.size() != 0 || in_valid || decoded_q.size() != 0);
  endtask

  // APB write of capacity, then read it back.
  task automatic cfg_write_capacity(logic [CAP_W-1:0] val);
    logic [CFG_DW-1:0] rd;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= REG_CAPACITY_ADDR;
    cfg_pwdata  <= {8'($urandom()), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cap_reg = val;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    check_field("capacity readback", rd[CAP_W-1:0], val);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CAP_W-1:0] cap;
    int unsigned      phase_items;
    bit               link_first, linked;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: copy step with no match before any start, literal
    // extremes, offset-one overlapping copy, clean end, byte after the end,
    // zero offset, byte sent while busy, empty final sequence.
    compressed_q.push_back(mk(OP_COPY, 8'h00, 1'b0));
    compressed_q.push_back(mk(OP_START_IND, 8'h00, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h20, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h00, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'hFF, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h01, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h00, 1'b0));
    repeat (5) compressed_q.push_back(mk(OP_COPY, 8'hFF, 1'b1));
    compressed_q.push_back(mk(OP_BYTE, 8'h10, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'hAA, 1'b1));
    compressed_q.push_back(mk(OP_BYTE, 8'h55, 1'b0));
    compressed_q.push_back(mk(OP_START_LINK, 8'hFF, 1'b1));
    compressed_q.push_back(mk(OP_BYTE, 8'h00, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h00, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h00, 1'b0));
    compressed_q.push_back(mk(OP_COPY, 8'h00, 1'b0));
    compressed_q.push_back(mk(OP_START_LINK, 8'h00, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h10, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h11, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h01, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h00, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h7F, 1'b0));
    compressed_q.push_back(mk(OP_START_IND, 8'h00, 1'b0));
    compressed_q.push_back(mk(OP_BYTE, 8'h0F, 1'b1));

    // Random phases. Each begins idle (sender has paused until all results are
    // back), sets the idle mix, writes capacity, then queues blocks.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      repeat (3) @(posedge clk);
      if (p < N_PHASES / 3) begin
        tx_idle_pct = 15;
        rx_idle_pct = 88;
      end else if (p < 2 * N_PHASES / 3) begin
        tx_idle_pct = 88;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      link_first = 1'b0;
      case (p % 6)
        0: cap = CAP_RESET;
        1: cap = '0;
        2: cap = CAP_W'($urandom_range(20, 150));
        3: begin
          // below the running count: a linked block runs out of space at once
          cap        = CAP_W'(produced >> 1);
          link_first = 1'b1;
        end
        4: cap = CAP_W'($urandom());
        default: cap = CAP_W'($urandom_range(150, 2000));
      endcase
      cfg_write_capacity(cap);
      @(negedge clk);
      gen_count   = produced;
      phase_items = 0;
      while (phase_items < 52) begin
        linked = link_first ||
                 (!gen_dirty && gen_count < cap_reg && $urandom_range(1) == 1);
        link_first = 1'b0;
        gen_block(linked, $urandom_range(1, 3));
        if ($urandom_range(99) < 20) corrupt_block();
        phase_items += blk_q.size();
        while (blk_q.size() != 0) compressed_q.push_back(blk_q.pop_front());
      end
      // receiver stops for a long stretch while the sender keeps offering
      if (p == 1 || p == N_PHASES - 2) begin
        @(posedge clk);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
    if (err_cnt == 0) begin
      $display("lz4_block_decompressor_top_tb: clean");
    end else begin
      $display("lz4_block_decompressor_top_tb: errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("lz4_block_decompressor_top_tb: errors");
    $finish;
  end

endmodule
